### sv/upstream_health_tracker_core_defines.svh
// ----------------------------------------------------------------------------
// upstream_health_tracker_core_defines.svh
// Assertion macros used by the upstream health tracker RTL.
// ----------------------------------------------------------------------------
`ifndef UPSTREAM_HEALTH_TRACKER_CORE_DEFINES_SVH
`define UPSTREAM_HEALTH_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTH
`define UHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upstream health tracker check failed");
`define UHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upstream health tracker check failed");
`else
`define UHT_ASSERT_IMPL(label, ante, cons)
`define UHT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/uht_pkg.sv
// ----------------------------------------------------------------------------
// uht_pkg
// Types and constants for the upstream health tracker.
// ----------------------------------------------------------------------------
package uht_pkg;

  localparam int TARGET_W = 4;
  localparam int TIME_W   = 48;
  localparam int COUNT_W  = 8;
  localparam int ACTIVE_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  localparam logic [ACTIVE_W-1:0] ACTIVE_COUNT_RST   = 5'd16;
  localparam logic [COUNT_W-1:0]  DEAD_THRESHOLD_RST = 8'd3;
  localparam logic [COUNT_W-1:0]  REVIVE_LIMIT_RST   = 8'd2;
  localparam logic [COUNT_W-1:0]  COUNT_MAX          = 8'hFF;

  typedef enum logic [1:0] {
    MODE_PROBE    = 2'd0,
    MODE_REQ_FAIL = 2'd1,
    MODE_REQ_OK   = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_COUNT   = 2'd0,
    REG_DEAD_THRESHOLD = 2'd1,
    REG_REVIVE_LIMIT   = 2'd2,
    REG_NONE           = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ACTIVE_W-1:0] active_count;
    logic [COUNT_W-1:0]  dead_threshold;
    logic [COUNT_W-1:0]  revive_limit;
  } cfg_t;

  typedef struct packed {
    mode_t               mode;
    logic [TARGET_W-1:0] target;
    logic                probe_ok;
    logic [TIME_W-1:0]   now_time;
  } event_t;

  typedef struct packed {
    logic               alive;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  stamp;
  } entry_t;

  typedef struct packed {
    logic               accepted;
    logic               is_alive;
    logic [COUNT_W-1:0] count_now;
    logic               went_up;
    logic               went_down;
    logic [TIME_W-1:0]  checked_at;
  } result_t;

endpackage

### sv/uht_entry_table.sv
// ----------------------------------------------------------------------------
// uht_entry_table
// Per-upstream state registers: alive flag, counter and probe timestamp.
// ----------------------------------------------------------------------------
module uht_entry_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  rd_idx,
  output uht_pkg::entry_t   rd_entry,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  uht_pkg::entry_t   wr_entry
);
  import uht_pkg::*;

  entry_t entries [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i].alive <= 1'b1;
        entries[i].count <= '0;
        entries[i].stamp <= '0;
      end
    end else if (wr_en) begin
      entries[wr_idx] <= wr_entry;
    end
  end

  assign rd_entry = entries[rd_idx];

endmodule

### sv/uht_update_logic.sv
// ----------------------------------------------------------------------------
// uht_update_logic
// Applies one event to an entry: threshold hysteresis and range checks.
// ----------------------------------------------------------------------------
module uht_update_logic #(
  parameter int MAX_UPSTREAMS = 16
) (
  input  uht_pkg::event_t  evt,
  input  uht_pkg::cfg_t    cfg,
  input  uht_pkg::entry_t  cur,
  output logic             applied,
  output uht_pkg::entry_t  upd,
  output uht_pkg::result_t res
);
  import uht_pkg::*;

  logic               in_range;
  logic [COUNT_W-1:0] cnt_inc;
  logic               alive_n;
  logic [COUNT_W-1:0] cnt_n;
  logic               up;
  logic               down;

  assign in_range = ({1'b0, evt.target} < cfg.active_count) &&
                    (32'(evt.target) < MAX_UPSTREAMS);
  assign applied  = in_range && (evt.mode != MODE_UNUSED);
  assign cnt_inc  = (cur.count == COUNT_MAX) ? COUNT_MAX : cur.count + 8'd1;

  always_comb begin
    alive_n = cur.alive;
    cnt_n   = cur.count;
    up      = 1'b0;
    down    = 1'b0;
    case (evt.mode)
      MODE_REQ_OK: begin
        cnt_n = '0;
      end
      MODE_PROBE, MODE_REQ_FAIL: begin
        if (evt.mode == MODE_PROBE && evt.probe_ok) begin
          if (!cur.alive) begin
            cnt_n = cnt_inc;
            if (cnt_inc >= cfg.revive_limit) begin
              alive_n = 1'b1;
              cnt_n   = '0;
              up      = 1'b1;
            end
          end else begin
            cnt_n = '0;
          end
        end else begin
          cnt_n = cnt_inc;
          if (cur.alive && cnt_inc >= cfg.dead_threshold) begin
            alive_n = 1'b0;
            down    = 1'b1;
          end
        end
      end
      default: begin
        cnt_n = cur.count;
      end
    endcase
  end

  always_comb begin
    upd.alive = alive_n;
    upd.count = cnt_n;
    upd.stamp = (evt.mode == MODE_PROBE) ? evt.now_time : cur.stamp;
  end

  always_comb begin
    res = '0;
    if (applied) begin
      res.accepted   = 1'b1;
      res.is_alive   = upd.alive;
      res.count_now  = upd.count;
      res.went_up    = up;
      res.went_down  = down;
      res.checked_at = upd.stamp;
    end
  end

endmodule

### sv/upstream_health_tracker_core.sv
// ----------------------------------------------------------------------------
// upstream_health_tracker_core
// Tracks alive state, a failure/revival counter and the last probe time for
// each upstream. Events arrive on the slave stream, one result leaves on the
// master stream per event. Each request is registered in the input register,
// then a read-modify-write on the entry table fills the result register that
// drives the master stream, so a new request is taken every cycle while the
// master side does not stall; the table is written in the same cycle it is
// read, so back-to-back requests to one upstream see each other's updates.
// A stalled master side holds the result register and then the input
// register.
// ----------------------------------------------------------------------------
`include "upstream_health_tracker_core_defines.svh"

module upstream_health_tracker_core #(
  parameter int MAX_UPSTREAMS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [3:0] target, [4] probe_ok, [52:5] now_time, [55:53] zero
  input  logic [uht_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] mode
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] is_alive, [8:1] count_now, [9] went_up, [10] went_down,
  // [58:11] checked_at, [63:59] zero
  output logic [uht_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] accepted
  output logic                             m_tuser,
  input  logic                             cfg_we,
  input  logic [uht_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uht_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import uht_pkg::*;

  localparam int DEPTH = (MAX_UPSTREAMS < (1 << TARGET_W)) ? MAX_UPSTREAMS
                                                           : (1 << TARGET_W);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t    cfg;
  logic    in_valid;
  event_t  in_evt;
  logic    advance;
  logic    applied;
  entry_t  cur_entry;
  entry_t  upd_entry;
  result_t res;
  result_t out_res;
  logic    out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_count   <= ACTIVE_COUNT_RST;
      cfg.dead_threshold <= DEAD_THRESHOLD_RST;
      cfg.revive_limit   <= REVIVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ACTIVE_COUNT:   cfg.active_count   <= cfg_data[ACTIVE_W-1:0];
        REG_DEAD_THRESHOLD: cfg.dead_threshold <= cfg_data;
        REG_REVIVE_LIMIT:   cfg.revive_limit   <= cfg_data;
        default:            cfg.active_count   <= cfg.active_count;
      endcase
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_evt.mode     <= mode_t'(s_tuser);
      in_evt.target   <= s_tdata[TARGET_W-1:0];
      in_evt.probe_ok <= s_tdata[TARGET_W];
      in_evt.now_time <= s_tdata[TARGET_W+TIME_W:TARGET_W+1];
    end
  end

  uht_entry_table #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (in_evt.target[IDX_W-1:0]),
    .rd_entry (cur_entry),
    .wr_en    (advance && applied),
    .wr_idx   (in_evt.target[IDX_W-1:0]),
    .wr_entry (upd_entry)
  );

  uht_update_logic #(
    .MAX_UPSTREAMS (MAX_UPSTREAMS)
  ) u_update (
    .evt     (in_evt),
    .cfg     (cfg),
    .cur     (cur_entry),
    .applied (applied),
    .upd     (upd_entry),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.accepted;
  assign m_tdata  = {5'd0, out_res.checked_at, out_res.went_down, out_res.went_up,
                     out_res.count_now, out_res.is_alive};

  `UHT_ASSERT_IMPL(a_no_up_and_down, m_tvalid, !(out_res.went_up && out_res.went_down))
  `UHT_ASSERT_IMPL(a_up_is_alive, m_tvalid && out_res.went_up,
                   out_res.is_alive && out_res.count_now == '0)
  `UHT_ASSERT_IMPL(a_down_is_dead, m_tvalid && out_res.went_down, !out_res.is_alive)
  `UHT_ASSERT_IMPL(a_reject_zero, m_tvalid && !out_res.accepted, m_tdata == '0)
  `UHT_ASSERT_NEXT(a_advance_fills, advance, m_tvalid)

endmodule

### tb/upstream_health_tracker_core_test.sv
// ----------------------------------------------------------------------------
// upstream_health_tracker_core_test
// Drives health events into the upstream health tracker under random stalls
// on both streams, keeps its own copy of the health table and compares every
// report field by field. Walks through several register settings: defaults,
// zero and full thresholds, no active entries, an oversized active count and
// a counter-saturation run on a single entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module upstream_health_tracker_core_test;
  import uht_pkg::*;

  class upstream_health_book;
    logic               alive_tab [16];
    logic [COUNT_W-1:0] count_tab [16];
    logic [TIME_W-1:0]  stamp_tab [16];
    logic [ACTIVE_W-1:0] active_count;
    logic [COUNT_W-1:0]  dead_thr;
    logic [COUNT_W-1:0]  revive_thr;
    result_t             pending_reports [$];
    int                  failures;

    function new();
      for (int i = 0; i < 16; i++) begin
        alive_tab[i] = 1'b1;
        count_tab[i] = '0;
        stamp_tab[i] = '0;
      end
      active_count = ACTIVE_COUNT_RST;
      dead_thr     = DEAD_THRESHOLD_RST;
      revive_thr   = REVIVE_LIMIT_RST;
      failures     = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_ACTIVE_COUNT:   active_count = v[ACTIVE_W-1:0];
        REG_DEAD_THRESHOLD: dead_thr = v;
        REG_REVIVE_LIMIT:   revive_thr = v;
        default: ;
      endcase
    endfunction

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
    endfunction

    function void record_event(mode_t mode, logic [TARGET_W-1:0] tgt, logic ok,
                               logic [TIME_W-1:0] now);
      result_t            r;
      int                 lim;
      logic [COUNT_W-1:0] c;
      logic               a;
      r = '0;
      lim = (int'(active_count) > 16) ? 16 : int'(active_count);
      if (mode == MODE_UNUSED || int'(tgt) >= lim) begin
        pending_reports.push_back(r);
        return;
      end
      c = count_tab[tgt];
      a = alive_tab[tgt];
      if (mode == MODE_REQ_OK) begin
        c = '0;
      end else if (mode == MODE_PROBE && ok) begin
        if (!a) begin
          c = bump(c);
          if (c >= revive_thr) begin
            a = 1'b1;
            c = '0;
            r.went_up = 1'b1;
          end
        end else begin
          c = '0;
        end
      end else begin
        c = bump(c);
        if (a && c >= dead_thr) begin
          a = 1'b0;
          r.went_down = 1'b1;
        end
      end
      if (mode == MODE_PROBE) stamp_tab[tgt] = now;
      count_tab[tgt] = c;
      alive_tab[tgt] = a;
      r.accepted   = 1'b1;
      r.is_alive   = a;
      r.count_now  = c;
      r.checked_at = stamp_tab[tgt];
      pending_reports.push_back(r);
    endfunction

    function bit field_ok(string name, logic [TIME_W-1:0] e, logic [TIME_W-1:0] a);
      if (a !== e) begin
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, e, a);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] data, logic acc);
      result_t e;
      bit      good;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, actual data %h user %b", $time, data, acc);
        failures++;
        return;
      end
      e = pending_reports.pop_front();
      good = 1'b1;
      good &= field_ok("accepted", e.accepted, acc);
      good &= field_ok("is_alive", e.is_alive, data[0]);
      good &= field_ok("count_now", e.count_now, data[8:1]);
      good &= field_ok("went_up", e.went_up, data[9]);
      good &= field_ok("went_down", e.went_down, data[10]);
      good &= field_ok("checked_at", e.checked_at, data[58:11]);
      if (!good) failures++;
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic [1:0]              s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic                    m_tuser;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  upstream_health_book book = new();
  bit                  calm = 1'b0;
  bit                  hold_req = 1'b0;
  int                  act_lim = 16;
  int                  idle_cycles = 0;

  localparam logic [TIME_W-1:0] TIME_ALL = {TIME_W{1'b1}};

  upstream_health_tracker_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_report(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    int run;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = 80;
        hold_req = 1'b0;
      end else begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      run = $urandom_range(1, 20);
      repeat (run) @(posedge clk);
    end
  end

  task automatic send_event(mode_t mode, logic [TARGET_W-1:0] tgt, logic ok,
                            logic [TIME_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, now, ok, tgt};
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
    book.record_event(mode, tgt, ok, now);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (book.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_register(idx, v);
    if (idx == REG_ACTIVE_COUNT) act_lim = int'(v[ACTIVE_W-1:0]);
    @(posedge clk);
  endtask

  task automatic setup(logic [7:0] act, logic [7:0] dead, logic [7:0] rev);
    drain();
    write_reg(REG_ACTIVE_COUNT, act);
    write_reg(REG_DEAD_THRESHOLD, dead);
    write_reg(REG_REVIVE_LIMIT, rev);
  endtask

  task automatic run_phase(int n, bit fail_bias);
    mode_t               mode;
    logic [TARGET_W-1:0] tgt;
    logic                ok;
    logic [63:0]         now;
    int                  lim;
    int                  r;
    for (int i = 0; i < n; i++) begin
      lim = (act_lim > 16) ? 16 : act_lim;
      r = $urandom_range(0, 99);
      if (fail_bias && (i < n - 40 || r < 85)) begin
        mode = MODE_REQ_FAIL;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) mode = MODE_UNUSED;
        else if (r < 50) mode = MODE_PROBE;
        else if (r < 78) mode = MODE_REQ_FAIL;
        else mode = MODE_REQ_OK;
      end
      if (fail_bias) begin
        tgt = (i >= n - 40 && $urandom_range(0, 9) == 0) ?
              TARGET_W'($urandom_range(0, 15)) : 4'd0;
      end else if (lim > 0 && $urandom_range(0, 99) < 88) begin
        tgt = TARGET_W'($urandom_range(0, lim - 1));
      end else begin
        tgt = TARGET_W'($urandom_range(0, 15));
      end
      ok  = 1'($urandom_range(0, 1));
      now = {$urandom(), $urandom()};
      send_event(mode, tgt, ok, now[TIME_W-1:0]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings: kill, shared counter, revival, timestamps
    send_event(MODE_PROBE, 4'd0, 1'b1, TIME_ALL);
    send_event(MODE_PROBE, 4'd1, 1'b0, '0);
    send_event(MODE_REQ_FAIL, 4'd1, 1'b0, 48'h123456789abc);
    send_event(MODE_REQ_FAIL, 4'd1, 1'b1, 48'h0f0f0f0f0f0f);
    send_event(MODE_REQ_FAIL, 4'd1, 1'b0, '0);
    send_event(MODE_PROBE, 4'd1, 1'b1, 48'ha5a5a5a5a5a5);
    for (int i = 0; i < 3; i++) send_event(MODE_REQ_FAIL, 4'd3, 1'b0, '0);
    send_event(MODE_REQ_OK, 4'd3, 1'b0, '0);
    send_event(MODE_PROBE, 4'd3, 1'b1, 48'h5a5a5a5a5a5a);
    send_event(MODE_PROBE, 4'd3, 1'b1, 48'h000000000001);
    send_event(MODE_REQ_OK, 4'd4, 1'b1, TIME_ALL);
    send_event(MODE_UNUSED, 4'd5, 1'b1, TIME_ALL);
    send_event(MODE_PROBE, 4'd15, 1'b0, TIME_ALL);
    send_event(MODE_REQ_OK, 4'd15, 1'b1, 48'h800000000000);

    // no active entries, then an oversized count, then a partial table
    drain();
    write_reg(REG_ACTIVE_COUNT, 8'd0);
    send_event(MODE_PROBE, 4'd0, 1'b1, TIME_ALL);
    drain();
    write_reg(REG_ACTIVE_COUNT, 8'hFF);
    send_event(MODE_REQ_FAIL, 4'd15, 1'b0, '0);
    drain();
    write_reg(REG_ACTIVE_COUNT, 8'd10);
    send_event(MODE_REQ_FAIL, 4'd10, 1'b0, '0);
    send_event(MODE_REQ_FAIL, 4'd9, 1'b0, '0);

    // zero thresholds act like one
    setup(8'd16, 8'd0, 8'd0);
    write_reg(REG_NONE, 8'h55);
    send_event(MODE_REQ_FAIL, 4'd6, 1'b0, '0);
    send_event(MODE_PROBE, 4'd6, 1'b1, 48'h00000000ffff);

    // random phases
    setup(8'd16, 8'd3, 8'd2);
    hold_req = 1'b1;
    run_phase(150, 1'b0);

    setup(8'd5, 8'd1, 8'd1);
    calm = 1'b1;
    run_phase(120, 1'b0);
    calm = 1'b0;

    setup(8'd0, 8'd2, 8'd2);
    run_phase(20, 1'b0);

    setup(8'd31, 8'd0, 8'd0);
    run_phase(100, 1'b0);

    // full thresholds on one entry: reach counter saturation
    setup(8'd1, 8'd255, 8'd255);
    run_phase(300, 1'b1);

    for (int p = 0; p < 3; p++) begin
      setup(8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)),
            8'($urandom_range(0, 6)));
      run_phase(80, 1'b0);
    end

    drain();
    if (book.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/uht_pkg.sv
sv/uht_entry_table.sv
sv/uht_update_logic.sv
sv/upstream_health_tracker_core.sv
tb/upstream_health_tracker_core_test.sv
